// ===== design/fct_pkg.sv =====
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types, sizes and helpers for the frequency count table.
// ----------------------------------------------------------------------------
package fct_pkg;

  localparam int unsigned ENTRIES    = 256;
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned IDX_BITS   = $clog2(ENTRIES);
  localparam int unsigned FILL_BITS  = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_BITS   = (COUNT_BITS > KEY_BITS) ? COUNT_BITS : KEY_BITS;

  // Command queue between front and back
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_BITS  = $clog2(QDEPTH);
  localparam int unsigned QCNT_BITS  = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2
  } action_e;

  typedef enum logic [0:0] {
    KIND_ANSWER = 1'b0,
    KIND_FULL   = 1'b1
  } reply_kind_e;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } st_e;

  typedef struct packed {
    action_e               action;
    logic [KEY_BITS-1:0]   operand;
  } cmd_t;

  // Command handoff from front to back
  typedef struct packed {
    logic vld;
    cmd_t cmd;
  } cmd_req_t;

  // A query hits when the frequency is non-negative and equals the count
  function automatic logic query_hit(input logic [COUNT_BITS-1:0] cnt,
                                     input logic [KEY_BITS-1:0]   freq);
    logic [CMP_BITS-1:0] cnt_ext;
    logic [CMP_BITS-1:0] freq_ext;
    cnt_ext  = CMP_BITS'(cnt);
    freq_ext = CMP_BITS'(freq);
    return !freq[KEY_BITS-1] && (cnt_ext == freq_ext);
  endfunction

endpackage

// ===== design/fct_front.sv =====
// ----------------------------------------------------------------------------
// fct_front
// Accept requests, drop unused action codes, queue commands for the back end.
// ----------------------------------------------------------------------------
module fct_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_vld_i,
  output logic                         in_rdy_o,
  input  logic [1:0]                   in_action_i,
  input  logic [fct_pkg::KEY_BITS-1:0] in_operand_i,
  output fct_pkg::cmd_req_t            cmd_req_o,
  input  logic                         cmd_pop_i
);

  fct_pkg::cmd_t                  q_mem [fct_pkg::QDEPTH];
  logic [fct_pkg::QPTR_BITS-1:0]  wr_ptr_q, wr_ptr_d;
  logic [fct_pkg::QPTR_BITS-1:0]  rd_ptr_q, rd_ptr_d;
  logic [fct_pkg::QCNT_BITS-1:0]  cnt_q, cnt_d;
  logic                           legal;
  logic                           push;
  logic                           pop;

  always_comb begin
    unique case (in_action_i)
      fct_pkg::ACT_ADD, fct_pkg::ACT_REMOVE, fct_pkg::ACT_QUERY: legal = 1'b1;
      default: legal = 1'b0;
    endcase
  end

  assign in_rdy_o = (cnt_q != fct_pkg::QCNT_BITS'(fct_pkg::QDEPTH));
  assign push     = in_vld_i && in_rdy_o && legal;
  assign pop      = cmd_pop_i && (cnt_q != '0);

  // Advance pointers, wrapping at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == fct_pkg::QPTR_BITS'(fct_pkg::QDEPTH - 1)) ? '0
                                                                        : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == fct_pkg::QPTR_BITS'(fct_pkg::QDEPTH - 1)) ? '0
                                                                        : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= '{action: fct_pkg::action_e'(in_action_i), operand: in_operand_i};
    end
  end

  assign cmd_req_o.vld = (cnt_q != '0);
  assign cmd_req_o.cmd = q_mem[rd_ptr_q];

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= fct_pkg::QCNT_BITS'(fct_pkg::QDEPTH))
    else $error("command queue overfilled");

  a_drop_illegal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_i && in_rdy_o && !legal && !pop) |=> cnt_q == $past(cnt_q))
    else $error("unused action code entered the queue");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_i && !push) |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("pop without a queued command");

endmodule

// ===== design/fct_back.sv =====
// ----------------------------------------------------------------------------
// fct_back
// Scan the table memories for each command, update counts, and emit replies.
// ----------------------------------------------------------------------------
module fct_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fct_pkg::cmd_req_t     cmd_req_i,
  output logic                  cmd_pop_o,
  output logic                  out_vld_o,
  input  logic                  out_rdy_i,
  output logic                  out_kind_o,
  output logic                  out_match_o
);

  logic [fct_pkg::KEY_BITS-1:0]   key_mem [fct_pkg::ENTRIES];
  logic [fct_pkg::COUNT_BITS-1:0] cnt_mem [fct_pkg::ENTRIES];

  fct_pkg::st_e                   state_q, state_d;
  fct_pkg::action_e               op_q, op_d;
  logic [fct_pkg::KEY_BITS-1:0]   operand_q, operand_d;
  logic [fct_pkg::FILL_BITS-1:0]  rd_idx_q, rd_idx_d;
  logic                           pend_q, pend_d;
  logic [fct_pkg::IDX_BITS-1:0]   pend_idx_q, pend_idx_d;
  logic                           hit_q, hit_d;
  logic [fct_pkg::IDX_BITS-1:0]   hit_idx_q, hit_idx_d;
  logic [fct_pkg::COUNT_BITS-1:0] hit_cnt_q, hit_cnt_d;
  logic [fct_pkg::FILL_BITS-1:0]  fill_q, fill_d;
  logic                           out_vld_q, out_vld_d;
  logic                           out_kind_q, out_kind_d;
  logic                           out_match_q, out_match_d;

  logic [fct_pkg::KEY_BITS-1:0]   key_rd_q;
  logic [fct_pkg::COUNT_BITS-1:0] cnt_rd_q;

  logic                           issue;
  logic                           hit_now;
  logic                           out_free;
  logic                           key_we;
  logic                           cnt_we;
  logic [fct_pkg::IDX_BITS-1:0]   wr_idx;
  logic [fct_pkg::COUNT_BITS-1:0] wr_cnt;

  assign out_free = !out_vld_q || out_rdy_i;

  always_comb begin
    if (op_q == fct_pkg::ACT_QUERY) begin
      hit_now = pend_q && fct_pkg::query_hit(cnt_rd_q, operand_q);
    end else begin
      hit_now = pend_q && (key_rd_q == operand_q);
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    operand_d   = operand_q;
    rd_idx_d    = rd_idx_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_cnt_d   = hit_cnt_q;
    fill_d      = fill_q;
    out_vld_d   = out_vld_q && !out_rdy_i;
    out_kind_d  = out_kind_q;
    out_match_d = out_match_q;
    cmd_pop_o   = 1'b0;
    issue       = 1'b0;
    key_we      = 1'b0;
    cnt_we      = 1'b0;
    wr_idx      = hit_idx_q;
    wr_cnt      = hit_cnt_q;

    unique case (state_q)
      fct_pkg::ST_IDLE: begin
        if (cmd_req_i.vld) begin
          cmd_pop_o = 1'b1;
          op_d      = cmd_req_i.cmd.action;
          operand_d = cmd_req_i.cmd.operand;
          rd_idx_d  = '0;
          hit_d     = 1'b0;
          state_d   = fct_pkg::ST_SCAN;
        end
      end
      fct_pkg::ST_SCAN: begin
        if (hit_now) begin
          hit_d     = 1'b1;
          hit_idx_d = pend_idx_q;
          hit_cnt_d = cnt_rd_q;
          state_d   = fct_pkg::ST_FINISH;
        end else if (rd_idx_q < fill_q) begin
          issue      = 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = rd_idx_q[fct_pkg::IDX_BITS-1:0];
          rd_idx_d   = rd_idx_q + 1'b1;
        end else if (!pend_q) begin
          state_d = fct_pkg::ST_FINISH;
        end
      end
      fct_pkg::ST_FINISH: begin
        unique case (op_q)
          fct_pkg::ACT_ADD: begin
            if (hit_q) begin
              cnt_we  = (hit_cnt_q != '1);
              wr_cnt  = hit_cnt_q + fct_pkg::COUNT_BITS'(1);
              state_d = fct_pkg::ST_IDLE;
            end else if (fill_q < fct_pkg::FILL_BITS'(fct_pkg::ENTRIES)) begin
              key_we  = 1'b1;
              cnt_we  = 1'b1;
              wr_idx  = fill_q[fct_pkg::IDX_BITS-1:0];
              wr_cnt  = fct_pkg::COUNT_BITS'(1);
              fill_d  = fill_q + 1'b1;
              state_d = fct_pkg::ST_IDLE;
            end else if (out_free) begin
              out_vld_d   = 1'b1;
              out_kind_d  = fct_pkg::KIND_FULL;
              out_match_d = 1'b0;
              state_d     = fct_pkg::ST_IDLE;
            end
          end
          fct_pkg::ACT_REMOVE: begin
            cnt_we  = hit_q && (hit_cnt_q != '0);
            wr_cnt  = hit_cnt_q - fct_pkg::COUNT_BITS'(1);
            state_d = fct_pkg::ST_IDLE;
          end
          fct_pkg::ACT_QUERY: begin
            if (out_free) begin
              out_vld_d   = 1'b1;
              out_kind_d  = fct_pkg::KIND_ANSWER;
              out_match_d = hit_q;
              state_d     = fct_pkg::ST_IDLE;
            end
          end
          default: state_d = fct_pkg::ST_IDLE;
        endcase
      end
      default: state_d = fct_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fct_pkg::ST_IDLE;
      pend_q    <= 1'b0;
      hit_q     <= 1'b0;
      fill_q    <= '0;
      rd_idx_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pend_q    <= pend_d;
      hit_q     <= hit_d;
      fill_q    <= fill_d;
      rd_idx_q  <= rd_idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    operand_q   <= operand_d;
    pend_idx_q  <= pend_idx_d;
    hit_idx_q   <= hit_idx_d;
    hit_cnt_q   <= hit_cnt_d;
    out_kind_q  <= out_kind_d;
    out_match_q <= out_match_d;
  end

  // Table memories: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_idx] <= operand_q;
    end
    if (cnt_we) begin
      cnt_mem[wr_idx] <= wr_cnt;
    end
    if (issue) begin
      key_rd_q <= key_mem[rd_idx_q[fct_pkg::IDX_BITS-1:0]];
      cnt_rd_q <= cnt_mem[rd_idx_q[fct_pkg::IDX_BITS-1:0]];
    end
  end

  assign out_vld_o   = out_vld_q;
  assign out_kind_o  = out_kind_q;
  assign out_match_o = out_match_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= fct_pkg::FILL_BITS'(fct_pkg::ENTRIES))
    else $error("fill level beyond table size");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + 1'b1))
    else $error("fill level moved by other than one");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fct_pkg::ST_SCAN) |-> (rd_idx_q <= fill_q))
    else $error("scan ran past filled slots");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (state_q == fct_pkg::ST_IDLE) && cmd_req_i.vld)
    else $error("command taken while busy");

endmodule

// ===== design/frequency_count_table_unit.sv =====
// Scan: a command that leaves the queue is matched against the table memory
//   at one entry per cycle on its read port, then a count is updated or a reply made.
// Commands: the back end works on one command at a time, and
//   a two-deep command queue keeps the input side taking requests meanwhile.
// Reset: asynchronous, active low; clears the fill level, queue and reply
//   register, so no clearing pass is needed and the table starts empty.
// ----------------------------------------------------------------------------
// frequency_count_table_unit
// Key/occurrence-count table answering "does any key occur exactly N times".
// ----------------------------------------------------------------------------
module frequency_count_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] operand (key or frequency)
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  // Reply stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] match, [7:1] zero
  output logic        m_axis_tuser    // [0] reply_kind
);

  fct_pkg::cmd_req_t cmd_req;
  logic              cmd_pop;
  logic              reply_kind;
  logic              reply_match;

  // Front end: accept requests, drop unused action codes, queue the rest
  fct_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_vld_i     (s_axis_tvalid),
    .in_rdy_o     (s_axis_tready),
    .in_action_i  (s_axis_tuser),
    .in_operand_i (s_axis_tdata),
    .cmd_req_o    (cmd_req),
    .cmd_pop_i    (cmd_pop)
  );

  // Back end: scan memories, update counts, hold replies in an output register
  // so a new command can start while a reply waits for the sink
  fct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_req_i   (cmd_req),
    .cmd_pop_o   (cmd_pop),
    .out_vld_o   (m_axis_tvalid),
    .out_rdy_i   (m_axis_tready),
    .out_kind_o  (reply_kind),
    .out_match_o (reply_match)
  );

  // Pack the reply: match in the low data bit, kind on tuser
  assign m_axis_tdata = {7'd0, reply_match};
  assign m_axis_tuser = reply_kind;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stream-level regression for the frequency count table. Requests of every
// action go in on the request stream. A model of the key/count table in the
// bench computes the reply, if any, for each accepted request. Each reply on
// the reply stream is compared with the oldest expected reply, field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Action code the block does not decode: it must change nothing and stay silent
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [fct_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam int unsigned POOL_SIZE = 16;

  typedef struct packed {
    fct_pkg::reply_kind_e kind;
    logic                 match;
  } table_reply_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // [31:0] operand (key or frequency)
  logic [1:0]  s_axis_tuser  = '0;   // [1:0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [0] match, [7:1] zero
  logic        m_axis_tuser;         // [0] reply_kind

  // Bench copy of the table
  logic [fct_pkg::KEY_BITS-1:0]   model_key   [fct_pkg::ENTRIES];
  logic [fct_pkg::COUNT_BITS-1:0] model_cnt   [fct_pkg::ENTRIES];
  bit                             model_valid [fct_pkg::ENTRIES];
  int unsigned                    model_fill;

  table_reply_t pending_replies[$];
  logic [31:0]  key_pool[POOL_SIZE];
  int unsigned  mismatch_count = 0;
  bit           no_idle        = 1'b0;

  frequency_count_table_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // Slot holding the key in the bench table, or -1 when absent
  function automatic int find_model_slot(input logic [fct_pkg::KEY_BITS-1:0] key);
    for (int i = 0; i < model_fill; i++) begin
      if (model_valid[i] && model_key[i] == key) return i;
    end
    return -1;
  endfunction

  // Apply one request to the bench table; return 1 when it yields a reply
  function automatic bit predict_table_op(input logic [1:0] act,
                                          input logic [31:0] opnd,
                                          output table_reply_t rep);
    int slot;
    rep.kind  = fct_pkg::KIND_ANSWER;
    rep.match = 1'b0;
    case (act)
      fct_pkg::ACT_ADD: begin
        slot = find_model_slot(opnd);
        if (slot >= 0) begin
          // Hold the count once it sits at the top of its range
          if (model_cnt[slot] != COUNT_MAX) model_cnt[slot] = model_cnt[slot] + 1'b1;
          return 1'b0;
        end
        if (model_fill >= fct_pkg::ENTRIES) begin
          // New key, no free slot: drop it and flag the rejection
          rep.kind = fct_pkg::KIND_FULL;
          return 1'b1;
        end
        model_key[model_fill]   = opnd;
        model_cnt[model_fill]   = fct_pkg::COUNT_BITS'(1);
        model_valid[model_fill] = 1'b1;
        model_fill++;
        return 1'b0;
      end
      fct_pkg::ACT_REMOVE: begin
        slot = find_model_slot(opnd);
        // Absent keys and counts already at zero stay as they are
        if (slot >= 0 && model_cnt[slot] != 0) model_cnt[slot] = model_cnt[slot] - 1'b1;
        return 1'b0;
      end
      fct_pkg::ACT_QUERY: begin
        // A negative frequency never matches; zero-counted entries still do
        if (!opnd[31]) begin
          for (int i = 0; i < model_fill; i++) begin
            if (model_valid[i] && 64'(model_cnt[i]) == 64'(opnd)) rep.match = 1'b1;
          end
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Present one request, wait for the handshake, then predict its reply
  task automatic send_request(input logic [1:0] act, input logic [31:0] opnd);
    table_reply_t rep;
    // Drop valid now and then, unless in a burst stretch
    if (!no_idle && $urandom_range(0, 99) < 13) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= opnd;
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (predict_table_op(act, opnd, rep)) pending_replies = {pending_replies, rep};
  endtask

  // Mostly small frequencies, since that is where the counts live
  function automatic logic [31:0] pick_frequency();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 8);
    if (r < 80) return $urandom_range(0, 40);
    return $urandom;
  endfunction

  // Refill the key pool: half keys already stored (if any), half fresh random keys
  task automatic refresh_key_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i % 2 == 0 && model_fill > 0)
        key_pool[i] = model_key[$urandom_range(0, model_fill - 1)];
      else
        key_pool[i] = $urandom;
    end
  endtask

  // Random requests on a small key pool so counts climb, fall and hit zero.
  // Undecoded actions ride along as noise and do not count toward n.
  task automatic run_mixed_ops(input int n);
    int unsigned r;
    int          sent;
    sent = 0;
    refresh_key_pool();
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if (r < 38) begin
        send_request(fct_pkg::ACT_ADD, key_pool[$urandom_range(0, POOL_SIZE - 1)]);
      end else if (r < 60) begin
        send_request(fct_pkg::ACT_REMOVE, key_pool[$urandom_range(0, POOL_SIZE - 1)]);
      end else if (r < 90) begin
        send_request(fct_pkg::ACT_QUERY, pick_frequency());
      end else if (r < 95) begin
        send_request(ACT_UNUSED, $urandom);
        continue;
      end else begin
        // Noise: a key from anywhere, mostly absent
        send_request($urandom_range(0, 1) ? fct_pkg::ACT_ADD : fct_pkg::ACT_REMOVE,
                     $urandom);
      end
      sent++;
    end
  endtask

  // Field extremes, every action, zero counts, negative queries, unused action
  task automatic test_directed();
    send_request(fct_pkg::ACT_QUERY, 32'd0);            // empty table, no match
    send_request(fct_pkg::ACT_QUERY, 32'hFFFF_FFFF);    // negative frequency
    send_request(fct_pkg::ACT_QUERY, 32'h8000_0000);    // most negative frequency
    send_request(fct_pkg::ACT_QUERY, 32'h7FFF_FFFF);    // beyond any reachable count
    send_request(fct_pkg::ACT_REMOVE, 32'd12345);       // remove from empty table
    send_request(fct_pkg::ACT_ADD, 32'h0000_0000);
    send_request(fct_pkg::ACT_ADD, 32'hFFFF_FFFF);
    send_request(fct_pkg::ACT_ADD, 32'h8000_0000);
    send_request(fct_pkg::ACT_ADD, 32'h7FFF_FFFF);
    send_request(fct_pkg::ACT_ADD, 32'h0000_0000);      // count 2
    send_request(fct_pkg::ACT_QUERY, 32'd1);
    send_request(fct_pkg::ACT_QUERY, 32'd2);
    send_request(fct_pkg::ACT_QUERY, 32'd3);
    send_request(fct_pkg::ACT_QUERY, 32'd0);            // nothing at zero yet
    send_request(fct_pkg::ACT_REMOVE, 32'hFFFF_FFFF);   // count reaches zero, entry stays
    send_request(fct_pkg::ACT_QUERY, 32'd0);
    send_request(fct_pkg::ACT_REMOVE, 32'hFFFF_FFFF);   // already zero, hold
    send_request(fct_pkg::ACT_REMOVE, 32'h1234_5678);   // absent key
    send_request(ACT_UNUSED, 32'hFFFF_FFFF);            // no reply, no change
    send_request(fct_pkg::ACT_QUERY, 32'hFFFF_FFFF);    // negative, zero-count entry present
    send_request(fct_pkg::ACT_ADD, 32'hFFFF_FFFF);      // revive zero-count entry
    send_request(fct_pkg::ACT_QUERY, 32'd0);
    send_request(fct_pkg::ACT_REMOVE, 32'h0000_0000);
    send_request(fct_pkg::ACT_QUERY, 32'd2);
  endtask

  task automatic test_random_mix();
    for (int phase = 0; phase < 5; phase++) run_mixed_ops(130);
  endtask

  // Back-to-back traffic with neither side idling
  task automatic test_burst_no_idle();
    no_idle = 1'b1;
    run_mixed_ops(100);
    no_idle = 1'b0;
  endtask

  // Fill every slot with distinct keys, then hammer the full table
  task automatic test_full_table();
    logic [31:0] key;
    while (model_fill < fct_pkg::ENTRIES) begin
      key = $urandom;
      if (find_model_slot(key) < 0) send_request(fct_pkg::ACT_ADD, key);
    end
    for (int i = 0; i < 6; i++) begin
      key = $urandom;
      send_request(fct_pkg::ACT_ADD, key);
    end
    run_mixed_ops(130);
  endtask

  // Receiver side: stall about 13 percent of the time, except in bursts
  always @(posedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 13);
  end

  // Compare each accepted reply with the oldest expected reply
  always @(posedge clk_i) begin : reply_check
    table_reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_replies.size() == 0) begin
        flag_mismatch("unexpected reply", {m_axis_tdata[6:0], m_axis_tuser}, 8'h00);
      end else begin
        want = pending_replies.pop_front();
        if (m_axis_tuser !== want.kind)
          flag_mismatch("reply_kind", 8'(m_axis_tuser), 8'(want.kind));
        if (m_axis_tdata[0] !== want.match)
          flag_mismatch("match", 8'(m_axis_tdata[0]), 8'(want.match));
        if (m_axis_tdata[7:1] !== 7'd0)
          flag_mismatch("tdata pad", 8'(m_axis_tdata[7:1]), 8'h00);
      end
    end
  end

  initial begin
    model_fill = 0;
    for (int i = 0; i < fct_pkg::ENTRIES; i++) model_valid[i] = 1'b0;
    // Hold reset at the start, then release it for good
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_mix();
    test_burst_no_idle();
    test_full_table();

    // Drain: wait for every reply, then cover work still in the command queue
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (4 * (fct_pkg::ENTRIES + 3)) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== frequency_count_table_unit.f =====
design/fct_pkg.sv
design/fct_front.sv
design/fct_back.sv
design/frequency_count_table_unit.sv
dv/tb_top.sv
